>>> rtl/fsrt_pkg.sv
// Package for the FEC shard receive tracker.
// Holds request, status and divider-step codes plus the controller/datapath
// command and status structs. No dependencies.
`default_nettype none
package fsrt_pkg;

   localparam int DEF_MAX_SHARDS   = 20;
   localparam int DEF_PACKET_BYTES = 1400;
   localparam int DEF_MAX_COLUMNS  = 64;

   localparam int PCT_SCALE = 100;
   localparam int PCT_ROUND = 99;

   // Operand width of the shared divider; covers frame size plus a rounding term.
   localparam int DIV_W = 24;
   localparam int IDX_W = 11;
   localparam int DEC_W = 7;

   localparam logic [1:0] REQ_PACKET = 2'd0;
   localparam logic [1:0] REQ_CHECK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [1:0] ST_ACCEPT    = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_RECOVERED = 2'd2;

   typedef enum logic [2:0] {
      DS_MAXDATA,
      DS_CEIL1,
      DS_COLS,
      DS_DATA,
      DS_PARITY,
      DS_FULLPKT,
      DS_PADDING,
      DS_INDEX
   } div_sel_type;

   typedef struct packed {
      logic        latch;
      logic        div_start;
      div_sel_type div_sel;
      logic        commit;
      logic        ctr_clear;
      logic        ctr_inc;
      logic        clr_wr;
      logic        rd_col;
      logic        pkt_wr;
      logic        chk_eval;
      logic        chk_fin;
      logic        flag_clr;
      logic        res_dup;
      logic        res_rcv;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       hit_recovered;
      logic       new_frame;
      logic       recovered;
      logic       pps_zero;
      logic       div_done;
      logic       ctr_last;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/fsrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fsrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/fsrt_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fsrt_pkg for the operand width.
`default_nettype none
module fsrt_divider
   import fsrt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic      [DIV_W-1:0] quotient,
   output logic      [DIV_W-1:0] remainder
);

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, quo_ff, den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [DIV_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_ff <= trial[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> rtl/fsrt_datapath.sv
// Datapath of the tracker: request registers, frame geometry, column RAM,
// shared divider and result registers. Depends on fsrt_pkg, fsrt_ram, fsrt_divider.
`default_nettype none
module fsrt_datapath
   import fsrt_pkg::*;
#(
   parameter int MAX_SHARDS   = DEF_MAX_SHARDS,
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [1:0]  req_type,
   input  wire logic [63:0] req_frame_index,
   input  wire logic [20:0] req_frame_bytes,
   input  wire logic [6:0]  req_fec_percent,
   input  wire logic [10:0] req_shard_packet_index,
   input  wire logic [31:0] req_link_packet_count,
   output logic      [1:0]  rsp_packet_status,
   output logic             rsp_failure_now,
   output logic             rsp_failure_sticky,
   output logic             rsp_check_ok,
   output logic      [6:0]  rsp_columns_to_decode
);

   localparam int CNTW    = $clog2(MAX_SHARDS + 1);
   localparam int CLW     = $clog2(MAX_COLUMNS + 1);
   localparam int AW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int EW      = MAX_SHARDS + 2 * CNTW + 1;
   localparam int MD_BASE = (MAX_SHARDS - 2) * PCT_SCALE + PCT_ROUND;

   // Reciprocals for the divisions by a constant; exact for any DIV_W-bit dividend.
   localparam int              PKT_SH  = DIV_W + $clog2(PACKET_BYTES);
   localparam longint unsigned PKT_RCP =
      ((64'd1 << PKT_SH) + 64'(PACKET_BYTES) - 64'd1) / 64'(PACKET_BYTES);
   localparam int              PCT_SH  = DIV_W + $clog2(PCT_SCALE);
   localparam longint unsigned PCT_RCP =
      ((64'd1 << PCT_SH) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE);

   // Request registers.
   logic [1:0]       type_ff;
   logic [63:0]      fi_ff;
   logic [20:0]      len_ff;
   logic [6:0]       fec_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0]      pc_ff;

   // Frame state.
   logic [63:0]      cur_ff;
   logic             recovered_ff, flag_ff;
   logic [CLW-1:0]   pps_ff, pad_ff;
   logic [CNTW-1:0]  data_ff, parity_ff, maxd_ff;
   logic [DIV_W-1:0] q1_ff, fdp_ff;
   logic [31:0]      nfs_ff;
   logic [IDX_W-1:0] shard_ff;
   logic [AW-1:0]    col_ff, ctr_ff;

   // Results.
   logic [1:0]       res_status_ff;
   logic             res_fail_ff, res_ok_ff, all_ff;
   logic [DEC_W-1:0] res_dec_ff;

   logic [DIV_W-1:0] div_n, div_d, div_q, div_r, colspb, ser_q;
   logic             div_done, ser_done;
   logic [CNTW-1:0]  total;

   logic             cdiv_sel, cdiv_v_ff, cdiv_done_ff, cdiv_pct_ff;
   logic [DIV_W-1:0] cdiv_n_ff, cdiv_q_ff;
   logic [63:0]      cdiv_prod;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   logic [MAX_SHARDS-1:0] rd_mask, pkt_mask, clr_mask;
   logic [CNTW-1:0]       rd_dcnt, rd_pcnt;
   logic                  rd_done, shard_bit, pkt_bad, pkt_is_data, pad_col;
   logic                  chk_full, chk_short;

   logic [31:0] tot_cols, dat_cols, par_cols, pc_start, pc_next;
   logic        start_fail;

   assign total  = CNTW'(data_ff + parity_ff);
   assign colspb = DIV_W'(pps_ff) * DIV_W'(PACKET_BYTES);

   always_comb begin
      case (cmd.div_sel)
         DS_MAXDATA: begin
            div_n = DIV_W'(MD_BASE) + DIV_W'(fec_ff);
            div_d = DIV_W'(PCT_SCALE) + DIV_W'(fec_ff);
         end
         DS_CEIL1: begin
            div_n = DIV_W'(len_ff) + DIV_W'(maxd_ff) - DIV_W'(1);
            div_d = DIV_W'(maxd_ff);
         end
         DS_COLS: begin
            div_n = q1_ff + DIV_W'(PACKET_BYTES - 1);
            div_d = DIV_W'(PACKET_BYTES);
         end
         DS_DATA: begin
            div_n = DIV_W'(len_ff) + colspb - DIV_W'(1);
            div_d = colspb;
         end
         DS_PARITY: begin
            div_n = DIV_W'(data_ff) * DIV_W'(fec_ff) + DIV_W'(PCT_ROUND);
            div_d = DIV_W'(PCT_SCALE);
         end
         DS_FULLPKT: begin
            div_n = DIV_W'(len_ff) + DIV_W'(PACKET_BYTES - 1);
            div_d = DIV_W'(PACKET_BYTES);
         end
         DS_PADDING: begin
            div_n = fdp_ff;
            div_d = DIV_W'(pps_ff);
         end
         default: begin
            div_n = DIV_W'(idx_ff);
            div_d = DIV_W'(pps_ff);
         end
      endcase
   end

   // Divisions by a constant go through a registered reciprocal multiply (operand
   // register, then product register); the rest use the serial divider.
   assign cdiv_sel  = cmd.div_sel inside {DS_COLS, DS_PARITY, DS_FULLPKT};
   assign cdiv_prod = cdiv_pct_ff ? ((64'(cdiv_n_ff) * PCT_RCP) >> PCT_SH)
                                  : ((64'(cdiv_n_ff) * PKT_RCP) >> PKT_SH);

   always_ff @(posedge clock) begin
      if (reset) begin
         cdiv_v_ff    <= 1'b0;
         cdiv_done_ff <= 1'b0;
      end else begin
         cdiv_v_ff    <= cmd.div_start && cdiv_sel;
         cdiv_done_ff <= cdiv_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         cdiv_n_ff   <= div_n;
         cdiv_pct_ff <= cmd.div_sel == DS_PARITY;
      end
      cdiv_q_ff <= DIV_W'(cdiv_prod);
   end

   fsrt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start && !cdiv_sel),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (ser_done),
      .quotient  (ser_q),
      .remainder (div_r)
   );

   assign div_done = ser_done || cdiv_done_ff;
   assign div_q    = cdiv_done_ff ? cdiv_q_ff : ser_q;

   // Column entry fields: {done, parity count, data count, missing mask}.
   assign rd_mask = rd_data[MAX_SHARDS-1:0];
   assign rd_dcnt = rd_data[MAX_SHARDS +: CNTW];
   assign rd_pcnt = rd_data[MAX_SHARDS + CNTW +: CNTW];
   assign rd_done = rd_data[EW-1];

   always_comb begin
      shard_bit = 1'b0;
      pkt_mask  = rd_mask;
      for (int i = 0; i < MAX_SHARDS; i++) begin
         if (shard_ff == IDX_W'(i)) begin
            shard_bit   = rd_mask[i];
            pkt_mask[i] = 1'b0;
         end
      end
   end

   assign pkt_bad     = (32'(shard_ff) >= 32'(total)) || !shard_bit;
   assign pkt_is_data = 32'(shard_ff) < 32'(data_ff);
   assign pad_col     = CLW'(ctr_ff) >= (pps_ff - pad_ff);

   // Fresh entry: bits below the shard total are missing; a padding column
   // already has its last data packet.
   always_comb begin
      for (int i = 0; i < MAX_SHARDS; i++) begin
         clr_mask[i] = (32'(i) < 32'(total)) &&
                       !(pad_col && (32'(i) == 32'(data_ff) - 32'd1));
      end
   end

   assign chk_full  = rd_dcnt == data_ff;
   assign chk_short = ({1'b0, rd_dcnt} + {1'b0, rd_pcnt}) < {1'b0, data_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ctr_ff;
      wr_data = rd_data;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_data = {1'b0, CNTW'(0), pad_col ? CNTW'(1) : CNTW'(0), clr_mask};
      end else if (cmd.pkt_wr) begin
         wr_en   = !pkt_bad;
         wr_addr = col_ff;
         wr_data = {rd_done,
                    pkt_is_data ? rd_pcnt : CNTW'(rd_pcnt + 1'b1),
                    pkt_is_data ? CNTW'(rd_dcnt + 1'b1) : rd_dcnt,
                    pkt_mask};
      end else if (cmd.chk_eval) begin
         wr_en   = !rd_done && !(!chk_full && chk_short);
         wr_data = {1'b1, rd_data[EW-2:0]};
      end
   end

   assign rd_addr = cmd.rd_col ? col_ff : ctr_ff;

   fsrt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_COLUMNS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Link counter prediction for the new frame.
   assign tot_cols = 32'(total) * 32'(pps_ff);
   assign dat_cols = 32'(data_ff) * 32'(pps_ff);
   assign par_cols = 32'(parity_ff) * 32'(pps_ff);
   always_comb begin
      if (pkt_is_data) begin
         pc_start = pc_ff - 32'(idx_ff);
         pc_next  = pc_ff - 32'(idx_ff) + tot_cols - 32'(pad_ff);
      end else begin
         pc_start = pc_ff - (32'(idx_ff) - 32'(pad_ff));
         pc_next  = pc_ff - (32'(idx_ff) - dat_cols) + par_cols;
      end
   end
   assign start_fail = !recovered_ff || ((nfs_ff != 32'd0) && (nfs_ff != pc_start));

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff <= req_type;
         fi_ff   <= req_frame_index;
         len_ff  <= req_frame_bytes;
         fec_ff  <= req_fec_percent;
         idx_ff  <= req_shard_packet_index;
         pc_ff   <= req_link_packet_count;
      end
      if (div_done) begin
         case (cmd.div_sel)
            DS_MAXDATA: maxd_ff <= div_q[CNTW-1:0];
            DS_CEIL1:   q1_ff   <= div_q;
            DS_FULLPKT: fdp_ff  <= div_q;
            DS_PADDING: pad_ff  <= (div_r == '0) ? CLW'(0) : CLW'(pps_ff - div_r[CLW-1:0]);
            DS_INDEX: begin
               shard_ff <= div_q[IDX_W-1:0];
               col_ff   <= div_r[AW-1:0];
            end
            default: ;
         endcase
      end
      if (cmd.ctr_clear) begin
         ctr_ff <= '0;
      end else if (cmd.ctr_inc) begin
         ctr_ff <= AW'(ctr_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '1;
         recovered_ff  <= 1'b1;
         flag_ff       <= 1'b0;
         pps_ff        <= '0;
         data_ff       <= '0;
         parity_ff     <= '0;
         nfs_ff        <= '0;
         res_status_ff <= ST_ACCEPT;
         res_fail_ff   <= 1'b0;
         res_ok_ff     <= 1'b0;
         res_dec_ff    <= '0;
         all_ff        <= 1'b1;
      end else begin
         if (cmd.latch) begin
            res_status_ff <= ST_ACCEPT;
            res_fail_ff   <= 1'b0;
            res_ok_ff     <= 1'b0;
            res_dec_ff    <= '0;
            all_ff        <= 1'b1;
         end
         if (div_done) begin
            case (cmd.div_sel)
               DS_COLS: begin
                  if (div_q == '0) begin
                     pps_ff <= CLW'(1);
                  end else if (div_q > DIV_W'(MAX_COLUMNS)) begin
                     pps_ff <= CLW'(MAX_COLUMNS);
                  end else begin
                     pps_ff <= div_q[CLW-1:0];
                  end
               end
               DS_DATA: begin
                  if (div_q == '0) begin
                     data_ff <= CNTW'(1);
                  end else if (div_q > DIV_W'(MAX_SHARDS)) begin
                     data_ff <= CNTW'(MAX_SHARDS);
                  end else begin
                     data_ff <= div_q[CNTW-1:0];
                  end
               end
               DS_PARITY: begin
                  if (DIV_W'(data_ff) + div_q > DIV_W'(MAX_SHARDS)) begin
                     parity_ff <= CNTW'(MAX_SHARDS) - data_ff;
                  end else begin
                     parity_ff <= div_q[CNTW-1:0];
                  end
               end
               default: ;
            endcase
         end
         if (cmd.commit) begin
            cur_ff       <= fi_ff;
            recovered_ff <= 1'b0;
            nfs_ff       <= pc_next;
            res_fail_ff  <= start_fail;
            if (start_fail) begin
               flag_ff <= 1'b1;
            end
         end
         if (cmd.pkt_wr) begin
            res_status_ff <= pkt_bad ? ST_DUPLICATE : ST_ACCEPT;
         end
         if (cmd.res_dup) begin
            res_status_ff <= ST_DUPLICATE;
         end
         if (cmd.res_rcv) begin
            res_status_ff <= ST_RECOVERED;
         end
         if (cmd.chk_eval && !rd_done && !chk_full) begin
            if (chk_short) begin
               all_ff <= 1'b0;
            end else begin
               res_dec_ff <= DEC_W'(res_dec_ff + 1'b1);
            end
         end
         if (cmd.chk_fin) begin
            res_ok_ff <= all_ff;
            if (all_ff) begin
               recovered_ff <= 1'b1;
            end
         end
         if (cmd.flag_clr) begin
            flag_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_packet_status     <= res_status_ff;
         rsp_failure_now       <= res_fail_ff;
         rsp_failure_sticky    <= flag_ff;
         rsp_check_ok          <= res_ok_ff;
         rsp_columns_to_decode <= res_dec_ff;
      end
   end

   assign stat.req_type      = type_ff;
   assign stat.hit_recovered = recovered_ff && (cur_ff == fi_ff);
   assign stat.new_frame     = cur_ff != fi_ff;
   assign stat.recovered     = recovered_ff;
   assign stat.pps_zero      = pps_ff == '0;
   assign stat.div_done      = div_done;
   assign stat.ctr_last      = CLW'(ctr_ff) == CLW'(pps_ff - 1'b1);

endmodule
`default_nettype wire

>>> rtl/fsrt_controller.sv
// Controller state machine of the tracker: request handshake, divider steps,
// column sweeps and result beat. Depends on fsrt_pkg.
`default_nettype none
module fsrt_controller
   import fsrt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DSTART, S_DWAIT, S_NEXT, S_CLR, S_PRD, S_PWR,
      S_CRD, S_CEV, S_CFIN, S_CLRF, S_RESP
   } state_type;

   state_type   state_ff;
   div_sel_type sel_ff;
   logic        new_ff, rsp_valid_ff, rsp_go;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_go    = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      cmd.latch     = req_valid && (state_ff == S_IDLE);
      cmd.div_start = state_ff == S_DSTART;
      cmd.commit    = state_ff == S_NEXT;
      cmd.clr_wr    = state_ff == S_CLR;
      cmd.rd_col    = state_ff == S_PRD;
      cmd.pkt_wr    = state_ff == S_PWR;
      cmd.chk_eval  = state_ff == S_CEV;
      cmd.chk_fin   = state_ff == S_CFIN;
      cmd.flag_clr  = state_ff == S_CLRF;
      cmd.rsp_load  = rsp_go;
      cmd.ctr_clear = (state_ff == S_NEXT) || (state_ff == S_DECODE);
      cmd.ctr_inc   = ((state_ff == S_CLR) || (state_ff == S_CEV)) && !stat.ctr_last;
      if (state_ff == S_DECODE && stat.req_type == REQ_PACKET) begin
         cmd.res_rcv = stat.hit_recovered;
         cmd.res_dup = !stat.hit_recovered && !stat.new_frame && stat.pps_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= DS_MAXDATA;
         new_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               case (stat.req_type)
                  REQ_PACKET: begin
                     if (stat.hit_recovered || (!stat.new_frame && stat.pps_zero)) begin
                        state_ff <= S_RESP;
                     end else begin
                        new_ff   <= stat.new_frame;
                        sel_ff   <= stat.new_frame ? DS_MAXDATA : DS_INDEX;
                        state_ff <= S_DSTART;
                     end
                  end
                  REQ_CHECK: state_ff <= stat.recovered ? S_RESP : S_CRD;
                  REQ_CLEAR: state_ff <= S_CLRF;
                  default:   state_ff <= S_RESP;
               endcase
            end
            S_DSTART: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (stat.div_done) begin
                  case (sel_ff)
                     DS_MAXDATA: begin sel_ff <= DS_CEIL1;   state_ff <= S_DSTART; end
                     DS_CEIL1:   begin sel_ff <= DS_COLS;    state_ff <= S_DSTART; end
                     DS_COLS:    begin sel_ff <= DS_DATA;    state_ff <= S_DSTART; end
                     DS_DATA:    begin sel_ff <= DS_PARITY;  state_ff <= S_DSTART; end
                     DS_PARITY:  begin sel_ff <= DS_FULLPKT; state_ff <= S_DSTART; end
                     DS_FULLPKT: begin sel_ff <= DS_PADDING; state_ff <= S_DSTART; end
                     DS_PADDING: begin sel_ff <= DS_INDEX;   state_ff <= S_DSTART; end
                     default:    state_ff <= new_ff ? S_NEXT : S_PRD;
                  endcase
               end
            end
            S_NEXT: state_ff <= S_CLR;
            S_CLR: begin
               if (stat.ctr_last) begin
                  state_ff <= S_PRD;
               end
            end
            S_PRD:  state_ff <= S_PWR;
            S_PWR:  state_ff <= S_RESP;
            S_CRD:  state_ff <= S_CEV;
            S_CEV:  state_ff <= stat.ctr_last ? S_CFIN : S_CRD;
            S_CFIN: state_ff <= S_RESP;
            S_CLRF: state_ff <= S_RESP;
            S_RESP: begin
               if (rsp_go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/fec_shard_receive_tracker_top.sv
// Top level of the FEC shard receive tracker: controller plus datapath.
// Depends on fsrt_pkg, fsrt_controller, fsrt_datapath.
//
//   channel   direction  handshake              beat contents
//   req       in         req_valid/req_ready    type, frame, size, fec, index, counter
//   rsp       out        rsp_valid/rsp_ready    status, failure, sticky, ok, decode count
//
// The block handles one item at a time, from acceptance in idle to the result load.
// A packet of a known frame runs an index division on the shared divider,
// then a column read and update.
// A first packet of a frame runs five serial divisions and three reciprocal
// divisions by constants, then a sweep that clears one column per cycle,
// then the column read and update.
// A check sweeps the columns, each with a RAM read and then an update.
// Reset is synchronous; a stalled result beat holds the next item in its last
// state until the output register frees.
`default_nettype none
module fec_shard_receive_tracker_top
   import fsrt_pkg::*;
#(
   parameter int MAX_SHARDS   = DEF_MAX_SHARDS,
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [63:0] req_frame_index,
   input  wire logic [20:0] req_frame_bytes,
   input  wire logic [6:0]  req_fec_percent,
   input  wire logic [10:0] req_shard_packet_index,
   input  wire logic [31:0] req_link_packet_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [1:0]  rsp_packet_status,
   output logic             rsp_failure_now,
   output logic             rsp_failure_sticky,
   output logic             rsp_check_ok,
   output logic      [6:0]  rsp_columns_to_decode
);

   cmd_type  cmd;
   stat_type stat;

   fsrt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fsrt_datapath #(
      .MAX_SHARDS   (MAX_SHARDS),
      .PACKET_BYTES (PACKET_BYTES),
      .MAX_COLUMNS  (MAX_COLUMNS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_type               (req_type),
      .req_frame_index        (req_frame_index),
      .req_frame_bytes        (req_frame_bytes),
      .req_fec_percent        (req_fec_percent),
      .req_shard_packet_index (req_shard_packet_index),
      .req_link_packet_count  (req_link_packet_count),
      .rsp_packet_status      (rsp_packet_status),
      .rsp_failure_now        (rsp_failure_now),
      .rsp_failure_sticky     (rsp_failure_sticky),
      .rsp_check_ok           (rsp_check_ok),
      .rsp_columns_to_decode  (rsp_columns_to_decode)
   );

endmodule
`default_nettype wire

>>> dv/tb_fec_shard_receive_tracker_top.sv
// Self-checking testbench for the FEC shard receive tracker top level.
// Depends on fsrt_pkg and fec_shard_receive_tracker_top; holds its own
// tracker predictor, a queued driver, a response monitor and the run control.
`default_nettype none
module tb_fec_shard_receive_tracker_top;
   import fsrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSHARD = 20;
   localparam int PKTB   = 1400;
   localparam int NCOL   = 64;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] frame;
      logic [20:0] bytes;
      logic [6:0]  fec;
      logic [10:0] idx;
      logic [31:0] lpc;
   } req_beat_type;

   typedef struct {
      logic [1:0] status;
      logic       fail_now;
      logic       sticky;
      logic       ok;
      logic [6:0] decoded;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [63:0] req_frame_index = '0;
   logic [20:0] req_frame_bytes = 21'd1;
   logic [6:0]  req_fec_percent = '0;
   logic [10:0] req_shard_packet_index = '0;
   logic [31:0] req_link_packet_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_packet_status;
   logic        rsp_failure_now;
   logic        rsp_failure_sticky;
   logic        rsp_check_ok;
   logic [6:0]  rsp_columns_to_decode;

   fec_shard_receive_tracker_top u_top (.*);

   // Predictor state.
   logic [63:0] cur_frame;
   logic        recovered;
   logic        sticky_fail;
   int unsigned pps, n_data, n_par;
   logic [31:0] miss_mask [NCOL];
   int unsigned dcnt [NCOL];
   int unsigned pcnt [NCOL];
   logic        col_done [NCOL];
   logic [31:0] next_start;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rsps[$];
   int errors = 0;
   int n_rsp = 0;
   int n_dup = 0, n_rcvd = 0, n_ok = 0, n_fail = 0;
   bit idle_free = 0;
   bit hold_rsp = 0;
   bit drv_pause = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned cdiv(int unsigned a, int unsigned b);
      return (a + b - 1) / b;
   endfunction

   task automatic tracker_reset();
      cur_frame = '1;
      recovered = 1'b1;
      sticky_fail = 1'b0;
      pps = 0; n_data = 0; n_par = 0;
      for (int c = 0; c < NCOL; c++) begin
         miss_mask[c] = '1; dcnt[c] = 0; pcnt[c] = 0; col_done[c] = 0;
      end
      next_start = '0;
   endtask

   function automatic logic open_frame(req_beat_type r);
      logic fail;
      int unsigned maxd, cols, dat, par, tot, pad, fdp, ix;
      logic [31:0] st, nx;
      fail = !recovered;
      ix = r.idx;
      maxd = ((NSHARD - 2) * 100 + 99 + r.fec) / (100 + r.fec);
      cur_frame = r.frame;
      recovered = 1'b0;
      cols = cdiv(cdiv(r.bytes, maxd), PKTB);
      if (cols == 0) cols = 1;
      if (cols > NCOL) cols = NCOL;
      dat = cdiv(r.bytes, cols * PKTB);
      if (dat == 0) dat = 1;
      if (dat > NSHARD) dat = NSHARD;
      par = (dat * r.fec + 99) / 100;
      if (dat + par > NSHARD) par = NSHARD - dat;
      tot = dat + par;
      pps = cols; n_data = dat; n_par = par;
      for (int c = 0; c < NCOL; c++) begin
         miss_mask[c] = (tot >= 32) ? '1 : ((32'd1 << tot) - 1);
         dcnt[c] = 0; pcnt[c] = 0; col_done[c] = 0;
      end
      fdp = cdiv(r.bytes, PKTB);
      pad = (cols - fdp % cols) % cols;
      for (int c = 0; c < pad; c++) begin
         miss_mask[cols - c - 1] &= ~(32'd1 << (dat - 1));
         dcnt[cols - c - 1]++;
      end
      if (ix / cols < dat) begin
         st = r.lpc - ix;
         nx = r.lpc - ix + tot * cols - pad;
      end else begin
         st = r.lpc - (ix - pad);
         nx = r.lpc - (ix - dat * cols) + par * cols;
      end
      if (next_start != 0 && next_start != st) fail = 1'b1;
      next_start = nx;
      if (fail) sticky_fail = 1'b1;
      return fail;
   endfunction

   function automatic rsp_beat_type tracker_step(req_beat_type r);
      rsp_beat_type o;
      int unsigned sh, col;
      logic all_ok;
      o = '{default: '0};
      if (r.kind == REQ_PACKET) begin
         if (recovered && cur_frame == r.frame) begin
            o.status = ST_RECOVERED;
         end else begin
            if (cur_frame != r.frame) o.fail_now = open_frame(r);
            if (pps == 0) begin
               o.status = ST_DUPLICATE;
            end else begin
               sh = r.idx / pps;
               col = r.idx % pps;
               if (sh >= n_data + n_par || col >= NCOL || !miss_mask[col][sh]) begin
                  o.status = ST_DUPLICATE;
               end else begin
                  miss_mask[col][sh] = 1'b0;
                  if (sh < n_data) dcnt[col]++;
                  else pcnt[col]++;
               end
            end
         end
      end else if (r.kind == REQ_CHECK) begin
         if (!recovered) begin
            all_ok = 1'b1;
            for (int c = 0; c < pps && c < NCOL; c++) begin
               if (col_done[c]) continue;
               if (dcnt[c] == n_data) begin
                  col_done[c] = 1; continue;
               end
               if (dcnt[c] + pcnt[c] < n_data) begin
                  all_ok = 1'b0; continue;
               end
               col_done[c] = 1;
               o.decoded++;
            end
            if (all_ok) recovered = 1'b1;
            o.ok = all_ok;
         end
      end else if (r.kind == REQ_CLEAR) begin
         sticky_fail = 1'b0;
      end
      o.sticky = sticky_fail;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on beat %0d: %s got %0d expected %0d", n_rsp, what, got, want);
      errors++;
   endtask

   // Driver: presents the oldest pending item and holds it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(tracker_step(pending_reqs.pop_front()));
         end
         if (pending_reqs.size() != 0 && !drv_pause &&
             (idle_free || $urandom_range(99) >= 8)) begin
            req_valid <= 1'b1;
            req_type <= pending_reqs[0].kind;
            req_frame_index <= pending_reqs[0].frame;
            req_frame_bytes <= pending_reqs[0].bytes;
            req_fec_percent <= pending_reqs[0].fec;
            req_shard_packet_index <= pending_reqs[0].idx;
            req_link_packet_count <= pending_reqs[0].lpc;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compares each response beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_beat_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_packet_status != e.status)
                  report_mismatch("packet_status", rsp_packet_status, e.status);
               if (rsp_failure_now != e.fail_now)
                  report_mismatch("failure_now", rsp_failure_now, e.fail_now);
               if (rsp_failure_sticky != e.sticky)
                  report_mismatch("failure_sticky", rsp_failure_sticky, e.sticky);
               if (rsp_check_ok != e.ok)
                  report_mismatch("check_ok", rsp_check_ok, e.ok);
               if (rsp_columns_to_decode != e.decoded)
                  report_mismatch("columns_to_decode", rsp_columns_to_decode, e.decoded);
               if (e.status == ST_DUPLICATE) n_dup++;
               if (e.status == ST_RECOVERED) n_rcvd++;
               if (e.ok) n_ok++;
               if (e.fail_now) n_fail++;
            end
         end
         rsp_ready <= !hold_rsp && (idle_free || $urandom_range(99) >= 8);
      end
   end

   // Receiver hold-off: the driver keeps offering beats so the block fills and stalls.
   initial begin
      wait (n_rsp > 700);
      hold_rsp = 1;
      repeat (3000) @(posedge clock);
      hold_rsp = 0;
   end

   function automatic req_beat_type make_req(logic [1:0] k, logic [63:0] f, int unsigned b,
                                             int unsigned fp, int unsigned ix,
                                             logic [31:0] l);
      req_beat_type r;
      r.kind = k; r.frame = f; r.bytes = 21'(b); r.fec = 7'(fp); r.idx = 11'(ix);
      r.lpc = l;
      return r;
   endfunction

   // Queues one frame: its packets in order or a random pick, with occasional
   // duplicates, then a check or two, with mostly consistent link counters.
   task automatic queue_frame(logic [63:0] f, logic [31:0] base);
      int unsigned b, fp, maxd, cols, dat, par, tot, pad, n, pick, drop;
      int unsigned ix;
      req_beat_type r;
      b = ($urandom_range(9) == 0) ? $urandom_range(1612800, 1) : $urandom_range(30000, 1);
      fp = $urandom_range(100);
      maxd = ((NSHARD - 2) * 100 + 99 + fp) / (100 + fp);
      cols = cdiv(cdiv(b, maxd), PKTB);
      if (cols == 0) cols = 1;
      if (cols > NCOL) cols = NCOL;
      dat = cdiv(b, cols * PKTB);
      if (dat > NSHARD) dat = NSHARD;
      par = (dat * fp + 99) / 100;
      if (dat + par > NSHARD) par = NSHARD - dat;
      tot = dat + par;
      pad = (cols - cdiv(b, PKTB) % cols) % cols;
      n = (tot * cols > 24) ? $urandom_range(24, 4) : tot * cols;
      drop = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
         ix = (n == tot * cols) ? i : $urandom_range(tot * cols - 1);
         if (n == tot * cols && drop == 0 && i == 0) continue;
         if ($urandom_range(19) == 0) ix = $urandom_range(2047);
         r = make_req(REQ_PACKET, f, b, fp, ix,
                      base + ((ix / cols < dat) ? ix : ix - pad));
         if ($urandom_range(29) == 0) r.lpc = $urandom;
         pending_reqs.push_back(r);
         if ($urandom_range(9) == 0) pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(REQ_CHECK, f, b, fp, 0, 0));
      if ($urandom_range(3) == 0)
         pending_reqs.push_back(make_req(REQ_PACKET, f, b, fp, 0, base));
      if ($urandom_range(3) == 0)
         pending_reqs.push_back(make_req(REQ_CHECK, f, b, fp, 0, 0));
      if ($urandom_range(7) == 0)
         pending_reqs.push_back(make_req(REQ_CLEAR, 64'($urandom), 1, 0, 0, 0));
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [63:0] fr;
      logic [31:0] base;
      tracker_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: check and clear from reset, extremes of size, fec and index.
      pending_reqs.push_back(make_req(REQ_CHECK, '1, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, '1, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_CLEAR, '0, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd0, 0, 0, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd0, 0, 0, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(REQ_CHECK, 64'd0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd1, 1612800, 100, 2047, 32'h8000_0000));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd1, 1612800, 100, 1279, 1));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd1, 1612800, 100, 0, 2));
      pending_reqs.push_back(make_req(REQ_CHECK, 64'd1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd2, 2097151, 127, 1000, 5));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd3, 26000, 0, 1, 7));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'd3, 26000, 0, 0, 6));
      pending_reqs.push_back(make_req(REQ_CHECK, 64'd3, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_CLEAR, '1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'hAAAA_5555_AAAA_5555, 1400, 50, 1,
                                      32'h5555_AAAA));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'hAAAA_5555_AAAA_5555, 1400, 50, 0,
                                      32'h5555_AAA9));
      pending_reqs.push_back(make_req(REQ_CHECK, 64'h0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(REQ_PACKET, 64'hAAAA_5555_AAAA_5555, 1400, 50, 0, 0));
      pending_reqs.push_back(make_req(2'd3, 64'h1234, 100, 10, 10, 10));
      wait_drained();

      // Random frames, mostly consecutive with matching counters.
      fr = {$urandom, $urandom};
      base = $urandom;
      while (n_rsp < 1600) begin
         if ($urandom_range(15) == 0) fr = {$urandom, $urandom};
         else fr = fr + (($urandom_range(9) == 0) ? 2 : 1);
         if ($urandom_range(11) == 0) base = $urandom;
         queue_frame(fr, base);
         base = next_start + $urandom_range(1);
         if ($urandom_range(39) == 0) begin
            pending_reqs.push_back(make_req(2'($urandom_range(3)), {$urandom, $urandom},
                                            $urandom, $urandom, $urandom, $urandom));
         end
         if (n_rsp > 300 && n_rsp < 400 && !idle_free) begin
            idle_free = 1;
         end else if (n_rsp >= 400) begin
            idle_free = 0;
         end
         wait_drained();
         if ($urandom_range(20) == 0) begin
            drv_pause = 1;
            wait_drained();
            repeat ($urandom_range(50)) @(posedge clock);
            drv_pause = 0;
         end
      end
      wait_drained();
      repeat (400) @(posedge clock);
      $display("covered %0d response beats: %0d duplicates, %0d recovered drops,", n_rsp,
               n_dup, n_rcvd);
      $display("%0d successful checks, %0d revealed failures", n_ok, n_fail);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire

>>> fec_shard_receive_tracker_top.f
rtl/fsrt_pkg.sv
rtl/fsrt_ram.sv
rtl/fsrt_divider.sv
rtl/fsrt_datapath.sv
rtl/fsrt_controller.sv
rtl/fec_shard_receive_tracker_top.sv
dv/tb_fec_shard_receive_tracker_top.sv
